@@ rtl/gfc_pkg.sv @@
// Package for the gamepad frame conditioner: constants, payload structs,
// sequencer states and the frame decision struct. No dependencies.
package gfc_pkg;

  localparam int PORT_COUNT = 7;
  localparam logic [6:0] PORT_MASK = 7'((1 << PORT_COUNT) - 1);
  localparam logic [2:0] NO_PORT = 3'd7;

  localparam int STICKS = 4;
  localparam logic [8:0] RAW_MIDPOINT = 9'd128;
  localparam logic [7:0] STICK_POS_SPAN = 8'd127;
  localparam logic [7:0] STICK_NEG_SPAN = 8'd128;

  localparam logic [6:0] DEADZONE_RESET = 7'd24;
  localparam logic [6:0] DEADZONE_MAX = 7'd100;

  localparam logic [9:0] STATUS_LIMIT = 10'd300;
  localparam logic [9:0] NO_PAD_MAX = 10'd1023;
  localparam logic [7:0] DATA_LIMIT = 8'd180;
  localparam logic [7:0] DATA_FAIL_MAX = 8'd255;

  localparam int DIVIDEND_W = 15;
  localparam int DIVISOR_W = 8;
  localparam int QUOT_W = 8;
  localparam int DIV_STEPS = QUOT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic       status_ok;
    logic [6:0] port_connected;
    logic [6:0] port_reassigned;
    logic       data_ok;
    logic [7:0] buttons_high;
    logic [7:0] buttons_low;
    logic [7:0] raw_right_x;
    logic [7:0] raw_right_y;
    logic [7:0] raw_left_x;
    logic [7:0] raw_left_y;
  } gfc_in_t;

  typedef struct packed {
    logic              pad_present;
    logic [2:0]        active_port;
    logic [15:0]       held_buttons;
    logic [15:0]       pressed_buttons;
    logic signed [7:0] stick_left_x;
    logic signed [7:0] stick_left_y;
    logic signed [7:0] stick_right_x;
    logic signed [7:0] stick_right_y;
    logic [6:0]        clear_requests;
    logic              restart_request;
    logic              actuator_forget;
  } gfc_out_t;

  typedef struct packed {
    logic       zero_pad;
    logic       load_data;
    logic       restart;
    logic       forget;
    logic [6:0] clears;
  } gfc_decision_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } gfc_state_t;

endpackage

@@ rtl/gfc_div.sv @@
// Shared restoring divider, one quotient bit per cycle, for stick rescaling.
// Depends on gfc_pkg for operand widths.
module gfc_div import gfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quotient
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [QUOT_W-1:0]    quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] divisor_r, divisor_nxt;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;
  logic [DIVISOR_W:0]   diff;
  logic [QUOT_W-1:0]    q_step;

  // Quotient fits in QUOT_W bits, so the upper dividend bits start below the divisor.
  always_comb begin
    trial  = {rem_r, quo_r[QUOT_W-1]};
    fits   = trial >= {1'b0, divisor_r};
    diff   = trial - {1'b0, divisor_r};
    q_step = {quo_r[QUOT_W-2:0], fits};
    done   = busy_r && (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
    quotient = q_step;

    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    divisor_nxt = divisor_r;
    if (start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      rem_nxt     = DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
      quo_nxt     = dividend[QUOT_W-1:0];
      divisor_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = q_step;
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    divisor_r <= divisor_nxt;
  end

endmodule

@@ rtl/gfc_frame.sv @@
// Per-frame port selection, failover and failure counters.
// Depends on gfc_pkg for limits and the decision struct.
module gfc_frame import gfc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          commit,
  input  logic          status_ok,
  input  logic [6:0]    port_connected,
  input  logic [6:0]    port_reassigned,
  input  logic          data_ok,
  output gfc_decision_t decision,
  output logic          present,
  output logic [2:0]    active_port
);

  logic [2:0] sel_r, sel_nxt;
  logic       present_r, present_nxt;
  logic [7:0] dfc_r, dfc_nxt;
  logic [9:0] np_r, np_nxt;

  logic [6:0] connected;
  logic [7:0] conn_ext;
  logic [2:0] lowest;
  logic [2:0] port;
  logic [9:0] np_inc;
  logic [7:0] dfc_base;
  logic [7:0] dfc_inc;

  always_comb begin
    connected = port_connected & PORT_MASK;
    conn_ext  = {1'b0, connected};
    lowest    = NO_PORT;
    for (int i = PORT_COUNT - 1; i >= 0; i--) begin
      if (connected[i]) begin
        lowest = 3'(i);
      end
    end
    np_inc = (np_r == NO_PAD_MAX) ? np_r : np_r + 10'd1;

    sel_nxt     = sel_r;
    present_nxt = present_r;
    dfc_nxt     = dfc_r;
    np_nxt      = np_r;
    decision    = '0;
    port        = NO_PORT;
    dfc_base    = dfc_r;
    dfc_inc     = dfc_r;

    if (!status_ok) begin
      present_nxt       = 1'b0;
      decision.zero_pad = 1'b1;
      np_nxt            = np_inc;
      if (np_inc == STATUS_LIMIT) begin
        sel_nxt          = NO_PORT;
        dfc_nxt          = '0;
        np_nxt           = '0;
        decision.restart = 1'b1;
        decision.forget  = 1'b1;
      end
    end else begin
      decision.clears = port_reassigned & PORT_MASK;
      // Keep the current port while it stays connected, else take the lowest one.
      if (sel_r < 3'(PORT_COUNT) && conn_ext[sel_r]) begin
        port = sel_r;
      end else begin
        port = lowest;
      end

      if (port == NO_PORT) begin
        present_nxt       = 1'b0;
        sel_nxt           = NO_PORT;
        decision.zero_pad = 1'b1;
        np_nxt            = np_inc;
      end else begin
        if (!present_r || port != sel_r) begin
          decision.clears   = decision.clears | (PORT_MASK & (7'd1 << port));
          decision.zero_pad = 1'b1;
          decision.forget   = 1'b1;
          dfc_base          = '0;
        end
        sel_nxt     = port;
        present_nxt = 1'b1;
        np_nxt      = '0;
        dfc_nxt     = dfc_base;
        if (!data_ok) begin
          dfc_inc = (dfc_base == DATA_FAIL_MAX) ? dfc_base : dfc_base + 8'd1;
          dfc_nxt = dfc_inc;
          if (dfc_inc == DATA_LIMIT) begin
            sel_nxt           = NO_PORT;
            dfc_nxt           = '0;
            np_nxt            = '0;
            decision.zero_pad = 1'b1;
            decision.restart  = 1'b1;
            decision.forget   = 1'b1;
          end
        end else begin
          dfc_nxt            = '0;
          decision.load_data = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= NO_PORT;
      present_r <= 1'b0;
      dfc_r     <= '0;
      np_r      <= '0;
    end else if (commit) begin
      sel_r     <= sel_nxt;
      present_r <= present_nxt;
      dfc_r     <= dfc_nxt;
      np_r      <= np_nxt;
    end
  end

  assign present     = present_r;
  assign active_port = sel_r;

endmodule

@@ rtl/gamepad_frame_conditioner_unit.sv @@
// A taken request goes to ST_DECIDE, then to ST_EMIT when there is no stick data;
// with stick data, each stick passes ST_PREP (setup, or zero inside the deadzone)
// and, outside the deadzone, ST_DIV on the single shared divider. ST_EMIT waits
// for a free output. One request at a time: the next is taken back in ST_IDLE.
// Synchronous active-low reset: no port selected, counters, buttons and sticks zero,
// deadzone 24. Uses gfc_pkg, gfc_frame and gfc_div.
module gamepad_frame_conditioner_unit import gfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  gfc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output gfc_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [6:0] cfg_data
);

  gfc_state_t state_r, state_nxt;

  gfc_in_t           in_r;
  logic [6:0]        deadzone_r;
  logic [15:0]       buttons_r;
  logic [15:0]       prev_buttons_r;
  logic signed [7:0] stick_r [STICKS];
  logic [1:0]        idx_r;
  logic              neg_r;
  logic [6:0]        clears_r;
  logic              restart_r;
  logic              forget_r;
  logic              out_valid_r;
  gfc_out_t          out_r;

  gfc_decision_t     decision;
  logic              frame_present;
  logic [2:0]        frame_port;
  logic              commit;

  logic [7:0]            raw;
  logic signed [8:0]     v;
  logic signed [8:0]     dz;
  logic signed [8:0]     pos_diff;
  logic signed [8:0]     neg_sum;
  logic                  in_dead;
  logic                  pos;
  logic [6:0]            pos_a;
  logic [7:0]            neg_m;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVISOR_W-1:0]  divisor;
  logic                  div_start;
  logic                  div_done;
  logic [QUOT_W-1:0]     quotient;
  logic                  last_stick;
  logic                  out_free;
  logic                  out_load;
  logic                  accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign cfg_ready = rst_n;
  assign commit    = (state_r == ST_DECIDE);
  assign out_free  = !out_valid_r || !out_stall;
  assign last_stick = (idx_r == 2'(STICKS - 1));

  gfc_frame u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .commit          (commit),
    .status_ok       (in_r.status_ok),
    .port_connected  (in_r.port_connected),
    .port_reassigned (in_r.port_reassigned),
    .data_ok         (in_r.data_ok),
    .decision        (decision),
    .present         (frame_present),
    .active_port     (frame_port)
  );

  gfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Deadzone test and operand setup for the stick under the index.
  always_comb begin
    case (idx_r)
      2'd0:    raw = in_r.raw_left_x;
      2'd1:    raw = in_r.raw_left_y;
      2'd2:    raw = in_r.raw_right_x;
      default: raw = in_r.raw_right_y;
    endcase
    v        = $signed({1'b0, raw}) - $signed(RAW_MIDPOINT);
    dz       = $signed({2'b00, deadzone_r});
    in_dead  = (v > -dz) && (v < dz);
    pos      = v > 9'sd0;
    pos_diff = v - dz;
    neg_sum  = -(v + dz);
    pos_a    = pos_diff[6:0];
    neg_m    = neg_sum[7:0];
    if (pos) begin
      // times 127 as shift and subtract
      dividend = DIVIDEND_W'({pos_a, 7'b0}) - DIVIDEND_W'(pos_a);
      divisor  = STICK_POS_SPAN - {1'b0, deadzone_r};
    end else begin
      dividend = DIVIDEND_W'({neg_m, 7'b0});
      divisor  = STICK_NEG_SPAN - {1'b0, deadzone_r};
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = decision.load_data ? ST_PREP : ST_EMIT;
      end
      ST_PREP: begin
        if (in_dead) begin
          state_nxt = last_stick ? ST_EMIT : ST_PREP;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = last_stick ? ST_EMIT : ST_PREP;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r     <= DEADZONE_RESET;
      buttons_r      <= '0;
      prev_buttons_r <= '0;
      for (int i = 0; i < STICKS; i++) begin
        stick_r[i] <= '0;
      end
      idx_r       <= '0;
      neg_r       <= 1'b0;
      clears_r    <= '0;
      restart_r   <= 1'b0;
      forget_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        deadzone_r <= (cfg_data > DEADZONE_MAX) ? DEADZONE_MAX : cfg_data;
      end

      if (state_r == ST_DECIDE) begin
        prev_buttons_r <= buttons_r;
        clears_r       <= decision.clears;
        restart_r      <= decision.restart;
        forget_r       <= decision.forget;
        idx_r          <= '0;
        if (decision.load_data) begin
          buttons_r <= {in_r.buttons_high, in_r.buttons_low};
        end else if (decision.zero_pad) begin
          buttons_r <= '0;
          for (int i = 0; i < STICKS; i++) begin
            stick_r[i] <= '0;
          end
        end
      end

      if (state_r == ST_PREP) begin
        if (in_dead) begin
          stick_r[idx_r] <= '0;
          idx_r          <= idx_r + 2'd1;
        end else begin
          neg_r <= !pos;
        end
      end

      if (state_r == ST_DIV && div_done) begin
        stick_r[idx_r] <= neg_r ? $signed(8'(-quotient)) : $signed(quotient);
        idx_r          <= idx_r + 2'd1;
      end

      // hold the result until the consumer takes it
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      in_r <= in_data;
    end
    if (out_load) begin
      out_r.pad_present     <= frame_present;
      out_r.active_port     <= frame_port;
      out_r.held_buttons    <= buttons_r;
      out_r.pressed_buttons <= buttons_r & ~prev_buttons_r;
      out_r.stick_left_x    <= stick_r[0];
      out_r.stick_left_y    <= stick_r[1];
      out_r.stick_right_x   <= stick_r[2];
      out_r.stick_right_y   <= stick_r[3];
      out_r.clear_requests  <= clears_r;
      out_r.restart_request <= restart_r;
      out_r.actuator_forget <= forget_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/gfc_checker.sv @@
// Port-level checks for the gamepad frame conditioner, bound to the top level.
// Depends on gfc_pkg and gamepad_frame_conditioner_unit.
module gfc_checker import gfc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input gfc_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time: busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in progress");

  a_restart_drops_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.restart_request |->
      out_data.actuator_forget && out_data.active_port == NO_PORT)
    else $error("restart without forget or with a port kept");

  a_absent_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pad_present |->
      out_data.held_buttons == '0 && out_data.pressed_buttons == '0 &&
      out_data.stick_left_x == '0 && out_data.stick_left_y == '0 &&
      out_data.stick_right_x == '0 && out_data.stick_right_y == '0)
    else $error("pad absent but buttons or sticks not released");

endmodule

bind gamepad_frame_conditioner_unit gfc_checker u_gfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/gamepad_frame_conditioner_unit_tb.sv @@
// Self-checking testbench for gamepad_frame_conditioner_unit: a queue-fed driver,
// a clocked monitor and a frame predictor that follows port selection, deadzone and
// failure counters. Depends on gfc_pkg and the unit's RTL only.
module gamepad_frame_conditioner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gfc_pkg::*;

  typedef enum int {
    FRAME_GOOD,
    FRAME_DATA_FAIL,
    FRAME_STATUS_FAIL,
    FRAME_NO_PAD,
    FRAME_NOISE
  } frame_kind_t;

  typedef struct {
    gfc_in_t     frame;
    int unsigned gap;
  } queued_frame_t;

  localparam int CYCLE_LIMIT = 600000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  gfc_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  gfc_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;

  gamepad_frame_conditioner_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted pad state
  logic [6:0]        dz_q = DEADZONE_RESET;
  logic [2:0]        port_sel = NO_PORT;
  logic              pad_up = 1'b0;
  logic [15:0]       held_word = '0;
  logic [15:0]       prev_word = '0;
  logic signed [7:0] stick_lx = '0, stick_ly = '0, stick_rx = '0, stick_ry = '0;
  logic [7:0]        data_fails = '0;
  logic [9:0]        no_pad_frames = '0;

  queued_frame_t frames_pending[$];
  gfc_out_t      frames_due[$];

  int          errors = 0;
  int          checked = 0;
  int          restarts = 0;
  int          acquisitions = 0;
  int          held_fails = 0;
  int          cycles = 0;
  int unsigned gap_waited = 0;
  int unsigned stall_left = 0;
  int unsigned queued = 0;
  bit          burst = 1'b0;
  logic [2:0]  home = '0;
  gfc_out_t    want;
  gfc_out_t    got;

  function automatic void release_pad();
    held_word = '0;
    stick_lx = '0;
    stick_ly = '0;
    stick_rx = '0;
    stick_ry = '0;
  endfunction

  function automatic void restart_pad();
    port_sel = NO_PORT;
    data_fails = '0;
    no_pad_frames = '0;
    release_pad();
  endfunction

  // Center at 128, zero inside the deadzone, rescale so full travel hits +127/-128.
  function automatic logic signed [7:0] deadzone_shape(logic [7:0] raw);
    int dz, v, m;
    dz = dz_q;
    v = int'(raw) - 128;
    if (v > -dz && v < dz) return '0;
    if (v > 0) return 8'(((v - dz) * 127) / (127 - dz));
    m = -(v + dz);
    return 8'(-((m * 128) / (128 - dz)));
  endfunction

  function automatic gfc_out_t condition_frame(gfc_in_t f);
    gfc_out_t   r;
    logic [6:0] live, clears;
    logic [2:0] port;
    logic       restart, forget;
    live = f.port_connected & PORT_MASK;
    clears = '0;
    restart = 1'b0;
    forget = 1'b0;
    port = NO_PORT;
    prev_word = held_word;
    if (!f.status_ok) begin
      pad_up = 1'b0;
      release_pad();
      if (no_pad_frames != NO_PAD_MAX) no_pad_frames++;
      if (no_pad_frames == STATUS_LIMIT) begin
        restart_pad();
        restart = 1'b1;
        forget = 1'b1;
      end
    end else begin
      clears = f.port_reassigned & PORT_MASK;
      // Keep the current port while it stays connected, else take the lowest one.
      if (port_sel < PORT_COUNT && live[port_sel]) begin
        port = port_sel;
      end else begin
        for (int i = PORT_COUNT - 1; i >= 0; i--)
          if (live[i]) port = 3'(i);
      end
      if (port == NO_PORT) begin
        pad_up = 1'b0;
        port_sel = NO_PORT;
        release_pad();
        if (no_pad_frames != NO_PAD_MAX) no_pad_frames++;
      end else begin
        if (!pad_up || port != port_sel) begin
          clears[port] = 1'b1;
          release_pad();
          forget = 1'b1;
          data_fails = '0;
        end
        port_sel = port;
        pad_up = 1'b1;
        no_pad_frames = '0;
        if (!f.data_ok) begin
          if (data_fails != DATA_FAIL_MAX) data_fails++;
          if (data_fails == DATA_LIMIT) begin
            restart_pad();
            restart = 1'b1;
            forget = 1'b1;
          end
        end else begin
          data_fails = '0;
          held_word = {f.buttons_high, f.buttons_low};
          stick_rx = deadzone_shape(f.raw_right_x);
          stick_ry = deadzone_shape(f.raw_right_y);
          stick_lx = deadzone_shape(f.raw_left_x);
          stick_ly = deadzone_shape(f.raw_left_y);
        end
      end
    end
    r.pad_present = pad_up;
    r.active_port = port_sel;
    r.held_buttons = held_word;
    r.pressed_buttons = held_word & ~prev_word;
    r.stick_left_x = stick_lx;
    r.stick_left_y = stick_ly;
    r.stick_right_x = stick_rx;
    r.stick_right_y = stick_ry;
    r.clear_requests = clears;
    r.restart_request = restart;
    r.actuator_forget = forget;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t ns: %s expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: present queued requests, honoring each one's leading gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_waited = 0;
    end else begin
      if (in_valid && !in_stall) begin
        got = condition_frame(in_data);
        frames_due.push_back(got);
        if (got.restart_request) restarts++;
        else if (got.actuator_forget) acquisitions++;
        if (in_data.status_ok && !in_data.data_ok && got.pad_present && !got.actuator_forget)
          held_fails++;
      end
      if (!in_valid || !in_stall) begin
        if (frames_pending.size() != 0 && gap_waited >= frames_pending[0].gap) begin
          in_data <= frames_pending[0].frame;
          in_valid <= 1'b1;
          void'(frames_pending.pop_front());
          gap_waited = 0;
        end else begin
          in_valid <= 1'b0;
          if (frames_pending.size() != 0) gap_waited++;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction, stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          want = frames_due.pop_front();
          check_field("pad_present", want.pad_present, out_data.pad_present);
          check_field("active_port", want.active_port, out_data.active_port);
          check_field("held_buttons", want.held_buttons, out_data.held_buttons);
          check_field("pressed_buttons", want.pressed_buttons, out_data.pressed_buttons);
          check_field("stick_left_x", want.stick_left_x, out_data.stick_left_x);
          check_field("stick_left_y", want.stick_left_y, out_data.stick_left_y);
          check_field("stick_right_x", want.stick_right_x, out_data.stick_right_x);
          check_field("stick_right_y", want.stick_right_y, out_data.stick_right_y);
          check_field("clear_requests", want.clear_requests, out_data.clear_requests);
          check_field("restart_request", want.restart_request, out_data.restart_request);
          check_field("actuator_forget", want.actuator_forget, out_data.actuator_forget);
          checked++;
        end
        stall_left = ((checked / 64) % 3 == 0) ? 0 : $urandom_range(0, 3);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, frames_due.size());
      $display("gamepad_frame_conditioner_unit_tb: errors");
      $finish;
    end
  end

  function automatic gfc_in_t frame_of(logic st, logic [6:0] conn, logic [6:0] reas,
                                       logic dat, logic [7:0] bh, logic [7:0] bl,
                                       logic [7:0] rx, logic [7:0] ry,
                                       logic [7:0] lx, logic [7:0] ly);
    gfc_in_t f;
    f = '{st, conn, reas, dat, bh, bl, rx, ry, lx, ly};
    return f;
  endfunction

  // Bias stick bytes toward the deadzone edges, the center and the ends of travel.
  function automatic logic [7:0] stick_raw();
    int dz;
    dz = dz_q;
    case ($urandom_range(0, 3))
      0: return 8'($urandom);
      1: return 8'(128 + dz + $urandom_range(0, 2) - 1);
      2: return 8'(128 - dz + $urandom_range(0, 2) - 1);
      default: return ($urandom_range(0, 2) == 0) ? 8'h80 :
                      ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
    endcase
  endfunction

  function automatic gfc_in_t build_frame(frame_kind_t kind);
    gfc_in_t    f;
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    f = bits[$bits(gfc_in_t)-1:0];
    if (kind == FRAME_GOOD || kind == FRAME_DATA_FAIL) begin
      f.status_ok = 1'b1;
      f.data_ok = (kind == FRAME_GOOD);
      f.port_connected = 7'(1 << home);
      if ($urandom_range(0, 2) == 0) f.port_connected |= 7'($urandom);
      f.port_reassigned = ($urandom_range(0, 4) == 0) ? 7'($urandom) : '0;
      f.raw_right_x = stick_raw();
      f.raw_right_y = stick_raw();
      f.raw_left_x = stick_raw();
      f.raw_left_y = stick_raw();
    end else if (kind == FRAME_STATUS_FAIL) begin
      f.status_ok = 1'b0;
    end else if (kind == FRAME_NO_PAD) begin
      f.status_ok = 1'b1;
      f.port_connected = '0;
    end
    return f;
  endfunction

  task automatic queue_frame(gfc_in_t f);
    queued_frame_t q;
    // Alternate stretches of back-to-back requests with gappy ones.
    if (queued % 40 == 0) burst = ($urandom_range(0, 3) == 0);
    q.frame = f;
    q.gap = burst ? 0 : $urandom_range(0, 3);
    frames_pending.push_back(q);
    queued++;
  endtask

  task automatic random_run(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) home = 3'($urandom_range(0, PORT_COUNT - 1));
      pick = $urandom_range(0, 99);
      if (pick < 55) queue_frame(build_frame(FRAME_GOOD));
      else if (pick < 70) queue_frame(build_frame(FRAME_DATA_FAIL));
      else if (pick < 80) queue_frame(build_frame(FRAME_STATUS_FAIL));
      else if (pick < 87) queue_frame(build_frame(FRAME_NO_PAD));
      else queue_frame(build_frame(FRAME_NOISE));
    end
  endtask

  // Frames without a pad; the 300th either trips the status restart or, as a
  // no-connect frame, lets the counter run on to saturation.
  task automatic pad_absent_run(int n, bit trip_restart);
    frame_kind_t kind;
    queue_frame(build_frame(FRAME_GOOD));
    for (int i = 0; i < n; i++) begin
      kind = ($urandom_range(0, 1) == 0) ? FRAME_STATUS_FAIL : FRAME_NO_PAD;
      if (i == int'(STATUS_LIMIT) - 1) kind = trip_restart ? FRAME_STATUS_FAIL : FRAME_NO_PAD;
      queue_frame(build_frame(kind));
    end
    queue_frame(build_frame(FRAME_GOOD));
  endtask

  task automatic data_fail_run();
    gfc_in_t f;
    home = 3'($urandom_range(0, PORT_COUNT - 1));
    for (int i = 0; i <= int'(DATA_LIMIT) + 3; i++) begin
      f = build_frame((i == 0 || i > int'(DATA_LIMIT)) ? FRAME_GOOD : FRAME_DATA_FAIL);
      // Hold a single port so the failure count is never reset by a failover.
      f.port_connected = 7'(1 << home);
      queue_frame(f);
    end
  endtask

  task automatic write_deadzone(logic [6:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dz_q = (value > DEADZONE_MAX) ? DEADZONE_MAX : value;
  endtask

  task automatic wait_idle();
    while (frames_pending.size() != 0 || in_valid || frames_due.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset deadzone of 24
    queue_frame(frame_of(1'b0, 7'h7F, 7'h7F, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    queue_frame(frame_of(1'b1, 7'h00, 7'h7F, 1'b1, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_frame(frame_of(1'b1, 7'h01, 7'h00, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h98));
    queue_frame(frame_of(1'b1, 7'h01, 7'h00, 1'b1, 8'h00, 8'h00, 8'h68, 8'h97, 8'h69, 8'h00));
    queue_frame(frame_of(1'b1, 7'h01, 7'h00, 1'b1, 8'hA5, 8'h5A, 8'h99, 8'h67, 8'h01, 8'hFE));
    queue_frame(frame_of(1'b1, 7'h01, 7'h00, 1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF));
    queue_frame(frame_of(1'b1, 7'h01, 7'h00, 1'b1, 8'hFF, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h80));
    queue_frame(frame_of(1'b1, 7'h7F, 7'h55, 1'b1, 8'h0F, 8'hF0, 8'h7F, 8'h81, 8'hFF, 8'h00));
    queue_frame(frame_of(1'b1, 7'h28, 7'h00, 1'b1, 8'hF0, 8'h0F, 8'h00, 8'hFF, 8'h98, 8'h68));
    queue_frame(frame_of(1'b1, 7'h40, 7'h2A, 1'b1, 8'h12, 8'h34, 8'hC0, 8'h40, 8'hE0, 8'h20));
    queue_frame(frame_of(1'b1, 7'h42, 7'h00, 1'b1, 8'hFF, 8'h34, 8'hC0, 8'h40, 8'hE0, 8'h20));
    queue_frame(frame_of(1'b0, 7'h40, 7'h7F, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    queue_frame(frame_of(1'b1, 7'h40, 7'h00, 1'b1, 8'h80, 8'h01, 8'h81, 8'h7F, 8'h99, 8'h67));
    queue_frame(frame_of(1'b1, 7'h02, 7'h01, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    queue_frame(frame_of(1'b1, 7'h02, 7'h00, 1'b1, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF));
    queue_frame(frame_of(1'b1, 7'h00, 7'h00, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    queue_frame(frame_of(1'b1, 7'h04, 7'h04, 1'b1, 8'h55, 8'hAA, 8'h00, 8'hFF, 8'h00, 8'hFF));
    wait_idle();

    write_deadzone(7'd0);
    random_run(70);
    wait_idle();

    write_deadzone(7'd100);
    random_run(70);
    wait_idle();

    // Out-of-range write saturates to 100
    write_deadzone(7'd127);
    pad_absent_run(int'(STATUS_LIMIT), 1'b1);
    data_fail_run();
    wait_idle();

    write_deadzone(7'($urandom_range(1, 99)));
    pad_absent_run(1050, 1'b0);
    random_run(60);
    wait_idle();

    write_deadzone(7'($urandom_range(0, 127)));
    random_run(95);
    wait_idle();

    $display("checked %0d frame results across six deadzone settings", checked);
    $display("saw %0d restarts, %0d port acquisitions, %0d held data failures",
             restarts, acquisitions, held_fails);
    if (errors == 0) $display("gamepad_frame_conditioner_unit_tb: clean");
    else $display("gamepad_frame_conditioner_unit_tb: errors");
    $finish;
  end

endmodule
